// ===== sv/kse_pkg.sv =====
// Shared types, constants and key code tables for the keypad scan event engine.
`default_nettype none

package kse_pkg;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int EXTRA_W  = 8;
    localparam int CODE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int HCOUNT_W = 2;
    localparam int BITIDX_W = 5;

    // Packed beat widths, rounded up to whole bytes
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 32;

    // Codes and status bits
    localparam logic [CODE_W-1:0] NO_CODE       = 8'hff;
    localparam logic [CODE_W-1:0] ST_FN         = 8'h80;
    localparam logic [CODE_W-1:0] ST_LAYOUT     = 8'h40;
    localparam logic [CODE_W-1:0] ST_PRESS      = 8'h02;
    localparam logic [CODE_W-1:0] ST_RELEASE    = 8'h01;
    localparam logic [7:0]        LED_TEST_BYTE = 8'h30;

    // Fn keys are key 15 and key 16, i.e. bit 14 and bit 15
    localparam logic [BITIDX_W-1:0] FN_BIT_A = 5'd14;
    localparam logic [BITIDX_W-1:0] FN_BIT_B = 5'd15;

    // Held count values
    localparam logic [HCOUNT_W-1:0] HELD_NONE   = 2'd0;
    localparam logic [HCOUNT_W-1:0] HELD_SINGLE = 2'd1;
    localparam logic [HCOUNT_W-1:0] HELD_PAIR   = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE           = 3'd0,
        EV_SINGLE_PRESS   = 3'd1,
        EV_PAIR_PRESS     = 3'd2,
        EV_SINGLE_RELEASE = 3'd3,
        EV_PAIR_RELEASE   = 3'd4
    } event_kind_t;

    // Key codes indexed by bit position (key number minus one)
    localparam logic [CODE_W-1:0] CODE_MAIN [32] = '{
        8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
        8'h19, 8'h10, 8'h20, 8'h1b, 8'h30, 8'h31, 8'h35, 8'h21,
        8'h00, 8'h3d, 8'h22, 8'h3a, 8'h35, 8'h33, 8'h21, 8'h32,
        8'h34, 8'h41, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hff
    };

    localparam logic [CODE_W-1:0] CODE_ALT [32] = '{
        8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
        8'h19, 8'h10, 8'h20, 8'h1b, 8'h30, 8'h31, 8'h35, 8'h21,
        8'h00, 8'h30, 8'h33, 8'h36, 8'h31, 8'h34, 8'h37, 8'h32,
        8'h35, 8'h41, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hff
    };

    // Index of the lowest set bit; zero when no bit is set
    function automatic logic [BITIDX_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [BITIDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BITIDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Key code for a bit position in the selected layout
    function automatic logic [CODE_W-1:0] key_code(input logic [BITIDX_W-1:0] idx,
                                                   input logic alt);
        return alt ? CODE_ALT[idx] : CODE_MAIN[idx];
    endfunction

endpackage

`default_nettype wire

// ===== sv/keypad_scan_event_engine_unit.sv =====
// Top level of the keypad scan event engine: input register, event logic, result register.
//
//  channel | dir | handshake          | beat content
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | one keypad scan (two reads, host flag)
//  m_      | out | m_tvalid/m_tready  | one result per scan (event, status, keys)
//  cfg_    | in  | cfg_wr_en          | pan_tilt_layout register, no read-back
//
// One scan per cycle sustained while m_ accepts; a scan taken on s_ passes through the
// input register and then the result register to m_. The event logic (two priority
// encoders and the code table) sits between those registers.
// aresetn clears both stage valids, the key state and the layout register.
// A stall on m_ holds the result register; the input register then still takes
// one more beat, and s_tready drops only when both stages are full.
`default_nettype none

module keypad_scan_event_engine_unit
    import kse_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input scan beat
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] scan_first_word, [39:32] scan_first_extra, [71:40] scan_second_word,
    // [79:72] scan_second_extra, [80] host_running, [87:81] zero
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // result beat
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] bounce, [3:1] event_kind, [4] transmit, [12:5] status_byte,
    // [20:13] first_key, [28:21] second_key, [29] led_test,
    // [30] restart_fn_timer, [31] zero
    output logic [M_DATA_W-1:0]       m_tdata,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [0:0]           cfg_wr_data
);

    logic                 in_valid_reg;
    logic [S_DATA_W-1:0]  in_data_reg;
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;
    logic                 advance;

    logic                 layout_reg;
    logic [CODE_W-1:0]    current_code_reg,  current_code_next;
    logic [CODE_W-1:0]    previous_code_reg, previous_code_next;
    logic [CODE_W-1:0]    pair0_reg,         pair0_next;
    logic [CODE_W-1:0]    pair1_reg,         pair1_next;
    logic [HCOUNT_W-1:0]  held_count_reg,    held_count_next;
    logic                 single_held_reg,   single_held_next;
    logic                 pair_held_reg,     pair_held_next;
    logic                 fn_active_reg,     fn_active_next;
    logic [M_DATA_W-1:0]  out_data_next;

    // Unpacked scan fields
    logic [WORD_W-1:0]    w1, w2, rest;
    logic [EXTRA_W-1:0]   x1, x2;
    logic                 run;
    logic                 stable, any0, any1;
    logic [BITIDX_W-1:0]  idx0, idx1;
    logic [CODE_W-1:0]    code0, code1;
    logic                 fn_hit, fn_now;

    assign w1  = in_data_reg[31:0];
    assign x1  = in_data_reg[39:32];
    assign w2  = in_data_reg[71:40];
    assign x2  = in_data_reg[79:72];
    assign run = in_data_reg[80];

    // Handshake: advance when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Find the first two pressed keys
    assign stable = (w1 == w2) && (x1 == x2);
    assign rest   = w1 & (w1 - WORD_W'(1));
    assign any0   = |w1;
    assign any1   = |rest;
    assign idx0   = lowest_set(w1);
    assign idx1   = lowest_set(rest);
    assign code0  = key_code(idx0, layout_reg);
    assign code1  = key_code(idx1, layout_reg);
    assign fn_hit = (any0 && (idx0 == FN_BIT_A || idx0 == FN_BIT_B)) ||
                    (any1 && (idx1 == FN_BIT_A || idx1 == FN_BIT_B));
    assign fn_now = fn_active_reg || fn_hit;

    // Event decision and next key state
    always_comb begin
        event_kind_t          kind;
        logic [CODE_W-1:0]    status;
        logic [CODE_W-1:0]    k0;
        logic [CODE_W-1:0]    k1;
        logic                 restart;
        logic [CODE_W-1:0]    base;

        current_code_next  = current_code_reg;
        previous_code_next = previous_code_reg;
        pair0_next         = pair0_reg;
        pair1_next         = pair1_reg;
        held_count_next    = held_count_reg;
        single_held_next   = single_held_reg;
        pair_held_next     = pair_held_reg;
        fn_active_next     = fn_active_reg;
        kind    = EV_NONE;
        status  = '0;
        k0      = '0;
        k1      = '0;
        restart = 1'b0;
        base    = (fn_now ? ST_FN : '0) | (layout_reg ? ST_LAYOUT : '0);

        if (!stable) begin
            out_data_next = M_DATA_W'(1);
        end else begin
            fn_active_next = fn_now;
            if (any0 && !any1) begin
                // single key
                if (code0 != NO_CODE && code0 != previous_code_reg && !single_held_reg) begin
                    previous_code_next = current_code_reg;
                    current_code_next  = code0;
                    held_count_next    = HELD_SINGLE;
                    single_held_next   = 1'b1;
                    status = base | ST_PRESS;
                    kind   = EV_SINGLE_PRESS;
                    k0     = code0;
                end
            end else if (any1) begin
                // key pair
                if (code0 != NO_CODE && !pair_held_reg) begin
                    pair0_next      = code0;
                    pair1_next      = code1;
                    held_count_next = HELD_PAIR;
                    pair_held_next  = 1'b1;
                    status = base | ST_PRESS;
                    kind   = EV_PAIR_PRESS;
                    k0     = code0;
                    k1     = code1;
                end
            end else begin
                // empty scan releases what is held
                if ((held_count_reg == HELD_SINGLE && single_held_reg) ||
                    (held_count_reg == HELD_PAIR && pair_held_reg)) begin
                    single_held_next   = 1'b0;
                    pair_held_next     = 1'b0;
                    previous_code_next = NO_CODE;
                    status = base | ST_RELEASE;
                    if (held_count_reg == HELD_SINGLE) begin
                        kind = EV_SINGLE_RELEASE;
                        k0   = current_code_reg;
                    end else begin
                        kind = EV_PAIR_RELEASE;
                        k0   = pair0_reg;
                        k1   = pair1_reg;
                    end
                    fn_active_next = 1'b0;
                    restart        = 1'b1;
                end
            end
            out_data_next = {1'b0, restart, (w1[31:24] == LED_TEST_BYTE), k1, k0, status,
                             (kind != EV_NONE) && run, kind, 1'b0};
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Layout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            layout_reg <= cfg_wr_data[0];
        end
    end

    // Key state, updated as each scan moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_code_reg  <= NO_CODE;
            previous_code_reg <= NO_CODE;
            pair0_reg         <= '0;
            pair1_reg         <= '0;
            held_count_reg    <= HELD_NONE;
            single_held_reg   <= 1'b0;
            pair_held_reg     <= 1'b0;
            fn_active_reg     <= 1'b0;
        end else if (advance) begin
            current_code_reg  <= current_code_next;
            previous_code_reg <= previous_code_next;
            pair0_reg         <= pair0_next;
            pair1_reg         <= pair1_next;
            held_count_reg    <= held_count_next;
            single_held_reg   <= single_held_next;
            pair_held_reg     <= pair_held_next;
            fn_active_reg     <= fn_active_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/kse_checker.sv =====
// Port-level checker for the keypad scan event engine, bound to the top level.
`default_nettype none

module kse_checker
    import kse_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // Result channel comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Bounce beat carries nothing but the bounce flag
    a_bounce_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[M_DATA_W-1:1] == '0)
        else $error("bounce beat with payload");

    // Transmit only with an event
    a_transmit_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3:1] != EV_NONE)
        else $error("transmit without event");

    // Timer restart only on a release, which sets the release status bit
    a_restart_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30] |->
            (m_tdata[3:1] == EV_SINGLE_RELEASE || m_tdata[3:1] == EV_PAIR_RELEASE) &&
            m_tdata[5])
        else $error("restart without release");

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

endmodule

bind keypad_scan_event_engine_unit kse_checker u_kse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== bench/kse_bench_pkg.sv =====
// Beat layouts, key maps and the predicting scoreboard for the keypad scan event bench.
package kse_bench_pkg;
    import kse_pkg::*;

    // Fn keys by key number
    localparam int FN_KEY_LO = 15;
    localparam int FN_KEY_HI = 16;

    // Key code per key number; entry 0 is unused, key 32 has no code
    localparam logic [7:0] STD_KEYMAP [33] = '{
        8'hff,
        8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
        8'h19, 8'h10, 8'h20, 8'h1b, 8'h30, 8'h31, 8'h35, 8'h21,
        8'h00, 8'h3d, 8'h22, 8'h3a, 8'h35, 8'h33, 8'h21, 8'h32,
        8'h34, 8'h41, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hff
    };

    localparam logic [7:0] ALT_KEYMAP [33] = '{
        8'hff,
        8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
        8'h19, 8'h10, 8'h20, 8'h1b, 8'h30, 8'h31, 8'h35, 8'h21,
        8'h00, 8'h30, 8'h33, 8'h36, 8'h31, 8'h34, 8'h37, 8'h32,
        8'h35, 8'h41, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hff
    };

    // Scan beat, lowest field last
    typedef struct packed {
        logic [6:0]  pad;
        logic        host_running;
        logic [7:0]  second_extra;
        logic [31:0] second_word;
        logic [7:0]  first_extra;
        logic [31:0] first_word;
    } scan_beat_t;

    // Result beat, lowest field last
    typedef struct packed {
        logic        pad;
        logic        restart_fn_timer;
        logic        led_test;
        logic [7:0]  second_key;
        logic [7:0]  first_key;
        logic [7:0]  status_byte;
        logic        transmit;
        event_kind_t event_kind;
        logic        bounce;
    } result_beat_t;

    class keypad_event_scoreboard;
        logic         alt_layout;
        logic [7:0]   live_code;
        logic [7:0]   last_code;
        logic [7:0]   pair_code [2];
        logic [1:0]   held_keys;
        logic         single_down;
        logic         pair_down;
        logic         fn_latched;
        result_beat_t expected_results [$];
        int           failures;

        function new();
            alt_layout   = 1'b0;
            live_code    = NO_CODE;
            last_code    = NO_CODE;
            pair_code[0] = 8'h00;
            pair_code[1] = 8'h00;
            held_keys    = HELD_NONE;
            single_down  = 1'b0;
            pair_down    = 1'b0;
            fn_latched   = 1'b0;
            failures     = 0;
        endfunction

        function void set_layout(logic value);
            alt_layout = value;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function logic [7:0] status_head();
            return (fn_latched ? ST_FN : 8'h00) | (alt_layout ? ST_LAYOUT : 8'h00);
        endfunction

        // Advance the key state by one accepted scan and queue its result
        function void note_scan(scan_beat_t sc);
            result_beat_t r;
            logic [7:0]   hit [2];
            int           hits;
            int           key_num;
            r      = '0;
            hit[0] = NO_CODE;
            hit[1] = NO_CODE;
            hits   = 0;
            if (sc.first_word != sc.second_word || sc.first_extra != sc.second_extra) begin
                r.bounce = 1'b1;
                expected_results.push_back(r);
                return;
            end
            r.led_test = (sc.first_word[31:24] == LED_TEST_BYTE);

            // lowest two pressed keys; an Fn key among them latches Fn at once
            for (int b = 0; b < 32; b++) begin
                if (sc.first_word[b] && hits < 2) begin
                    key_num   = b + 1;
                    hit[hits] = alt_layout ? ALT_KEYMAP[key_num] : STD_KEYMAP[key_num];
                    if (key_num == FN_KEY_LO || key_num == FN_KEY_HI) begin
                        fn_latched = 1'b1;
                    end
                    hits++;
                end
            end

            if (hits == 1) begin
                if (hit[0] != NO_CODE && hit[0] != last_code && !single_down) begin
                    last_code     = live_code;
                    live_code     = hit[0];
                    held_keys     = HELD_SINGLE;
                    single_down   = 1'b1;
                    r.status_byte = status_head() | ST_PRESS;
                    r.event_kind  = EV_SINGLE_PRESS;
                    r.first_key   = live_code;
                end
            end else if (hits == 2) begin
                if (hit[0] != NO_CODE && !pair_down) begin
                    pair_code[0]  = hit[0];
                    pair_code[1]  = hit[1];
                    held_keys     = HELD_PAIR;
                    pair_down     = 1'b1;
                    r.status_byte = status_head() | ST_PRESS;
                    r.event_kind  = EV_PAIR_PRESS;
                    r.first_key   = pair_code[0];
                    r.second_key  = pair_code[1];
                end
            end else if ((held_keys == HELD_SINGLE && single_down) ||
                         (held_keys == HELD_PAIR && pair_down)) begin
                // empty scan releases; Fn drops after the status is formed
                single_down   = 1'b0;
                pair_down     = 1'b0;
                last_code     = NO_CODE;
                r.status_byte = status_head() | ST_RELEASE;
                if (held_keys == HELD_SINGLE) begin
                    r.event_kind = EV_SINGLE_RELEASE;
                    r.first_key  = live_code;
                end else begin
                    r.event_kind = EV_PAIR_RELEASE;
                    r.first_key  = pair_code[0];
                    r.second_key = pair_code[1];
                end
                fn_latched         = 1'b0;
                r.restart_fn_timer = 1'b1;
            end
            r.transmit = (r.event_kind != EV_NONE) && sc.host_running;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
            if (seen !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
                failures++;
            end
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_result(result_beat_t seen);
            result_beat_t want;
            if (expected_results.size() == 0) begin
                $error("result beat 0x%0h with no scan outstanding", seen);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("bounce", want.bounce, seen.bounce);
            compare_field("event_kind", want.event_kind, seen.event_kind);
            compare_field("transmit", want.transmit, seen.transmit);
            compare_field("status_byte", want.status_byte, seen.status_byte);
            compare_field("first_key", want.first_key, seen.first_key);
            compare_field("second_key", want.second_key, seen.second_key);
            compare_field("led_test", want.led_test, seen.led_test);
            compare_field("restart_fn_timer", want.restart_fn_timer, seen.restart_fn_timer);
            compare_field("pad", want.pad, seen.pad);
        endfunction
    endclass

endpackage

// ===== bench/testbench.sv =====
// Testbench top: drives keypad scans and layout writes, checks every result beat.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kse_pkg::*;
    import kse_bench_pkg::*;

    localparam int LONG_STALL_CYCLES = 40;
    localparam int DRAIN_SLACK       = 4;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wr_en;
    logic [0:0]          cfg_wr_data;

    keypad_event_scoreboard scoreboard;
    int   scans_sent = 0;
    logic calm = 1'b0;
    logic long_stall_req = 1'b0;

    keypad_scan_event_engine_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Observe accepted beats and layout writes at each edge
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_tvalid && s_tready) begin
                scoreboard.note_scan(scan_beat_t'(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                scoreboard.check_result(result_beat_t'(m_tdata));
            end
            if (cfg_wr_en) begin
                scoreboard.set_layout(cfg_wr_data[0]);
            end
        end
    end

    // Result side: random stall bursts, one long hold on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (long_stall_req) begin
                long_stall_req = 1'b0;
                stall_left     = LONG_STALL_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic scan_beat_t make_scan(logic [31:0] w1, logic [7:0] x1,
                                             logic [31:0] w2, logic [7:0] x2, logic run);
        scan_beat_t sc;
        sc              = '0;
        sc.first_word   = w1;
        sc.first_extra  = x1;
        sc.second_word  = w2;
        sc.second_extra = x2;
        sc.host_running = run;
        return sc;
    endfunction

    function automatic scan_beat_t steady_scan(logic [31:0] w, logic [7:0] x, logic run);
        return make_scan(w, x, w, x, run);
    endfunction

    function automatic logic host_flag();
        return $urandom_range(0, 3) != 0;
    endfunction

    // Mostly one or two keys, sometimes an Fn combination or a full random word
    function automatic logic [31:0] pick_keys();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: k = 32'h1 << $urandom_range(0, 31);
            5, 6, 7:       k = (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31));
            8:             k = (32'h1 << $urandom_range(14, 15)) | (32'h1 << $urandom_range(0, 31));
            default:       k = $urandom();
        endcase
        if ($urandom_range(0, 15) == 0) begin
            k[31:24] = LED_TEST_BYTE;
        end
        return k;
    endfunction

    // Two reads that differ in exactly one bit
    function automatic scan_beat_t bounced_scan(logic [31:0] w);
        scan_beat_t sc;
        sc = steady_scan(w, 8'($urandom), host_flag());
        if ($urandom_range(0, 2) == 0) begin
            sc.second_extra ^= 8'h1 << $urandom_range(0, 7);
        end else begin
            sc.second_word ^= 32'h1 << $urandom_range(0, 31);
        end
        return sc;
    endfunction

    function automatic scan_beat_t noise_scan();
        scan_beat_t sc;
        sc = steady_scan($urandom(), 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 1) == 0) begin
            sc.second_word  = $urandom();
            sc.second_extra = 8'($urandom);
        end
        return sc;
    endfunction

    // Offer one scan beat, hold until taken, then maybe idle
    task automatic send_scan(input scan_beat_t sc);
        s_tdata  <= sc;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        scans_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (scoreboard.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic write_layout(input logic value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Press, hold with some bounce, maybe change keys, then release
    task automatic key_episode();
        logic [31:0] keys;
        keys = pick_keys();
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 5) == 0) begin
                send_scan(bounced_scan(keys));
            end
            send_scan(steady_scan(keys, 8'($urandom), host_flag()));
        end
        if ($urandom_range(0, 3) == 0) begin
            send_scan(steady_scan(pick_keys(), 8'($urandom), host_flag()));
        end
        repeat ($urandom_range(1, 2)) begin
            send_scan(steady_scan(32'h0, 8'($urandom), host_flag()));
        end
    endtask

    task automatic random_scans(input int count);
        int stop_at;
        stop_at = scans_sent + count;
        while (scans_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                send_scan(noise_scan());
            end else begin
                key_episode();
            end
        end
    endtask

    // Standard layout corner cases, straight out of reset
    task automatic directed_scans();
        send_scan(steady_scan(32'h0, 8'h00, 1'b1));                    // nothing held
        send_scan(make_scan(32'h0, 8'h00, 32'h1, 8'h00, 1'b1));        // bounce in key bytes
        send_scan(make_scan('1, 8'h00, '1, 8'hff, 1'b1));              // bounce in byte 4 only
        send_scan(steady_scan(32'h1, 8'h00, 1'b1));                    // key 1 press
        send_scan(steady_scan(32'h1, 8'h00, 1'b1));                    // still held
        send_scan(steady_scan(32'h0, 8'hff, 1'b1));                    // single release
        send_scan(steady_scan(32'h8000_0000, 8'h00, 1'b1));            // key 32 alone, no code
        send_scan(steady_scan(32'h0000_4000, 8'h00, 1'b0));            // Fn key 15, host stopped
        send_scan(steady_scan(32'h0, 8'h00, 1'b1));                    // release clears Fn
        send_scan(steady_scan(32'h8000_8000, 8'h00, 1'b1));            // Fn key 16 with key 32
        send_scan(steady_scan(32'h0000_0010, 8'h00, 1'b1));            // single over held pair
        send_scan(steady_scan(32'h0, 8'h00, 1'b1));                    // releases as single
        send_scan(steady_scan('1, 8'hff, 1'b1));                       // every key down
        send_scan(steady_scan(32'h3000_0000, 8'h5a, 1'b1));            // LED test, pair held
        send_scan(steady_scan(32'h0, 8'h00, 1'b1));                    // pair release
        send_scan(steady_scan(32'h3000_0000, 8'ha5, 1'b1));            // LED test pair press
        send_scan(steady_scan(32'h0, 8'h00, 1'b0));                    // release, not sent
        send_scan(steady_scan(32'h4000_0000, 8'ha5, 1'b1));            // key 31
        send_scan(make_scan(32'h4000_0000, 8'ha5, 32'h4000_0000, 8'ha4, 1'b1));
        send_scan(steady_scan(32'h0, 8'h00, 1'b1));
    endtask

    // Alternate layout keys 18 to 23 as pairs, key 25 alone
    task automatic alt_layout_scans();
        send_scan(steady_scan(32'h0006_0000, 8'h00, 1'b1));
        send_scan(steady_scan(32'h0, 8'h00, 1'b1));
        send_scan(steady_scan(32'h0018_0000, 8'h00, 1'b1));
        send_scan(steady_scan(32'h0, 8'h00, 1'b1));
        send_scan(steady_scan(32'h0060_0000, 8'h00, 1'b1));
        send_scan(steady_scan(32'h0, 8'h00, 1'b1));
        send_scan(steady_scan(32'h0100_0000, 8'h00, 1'b1));
        send_scan(steady_scan(32'h0, 8'h00, 1'b1));
    endtask

    initial begin : stimulus
        scoreboard = new();
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_scans();
        drain_results();

        // alternate layout; hold the result side long enough to back up the input
        write_layout(1'b1);
        alt_layout_scans();
        random_scans(200);
        long_stall_req = 1'b1;
        random_scans(300);
        drain_results();

        // standard layout with a full pause in the middle
        write_layout(1'b0);
        random_scans(250);
        drain_results();
        random_scans(250);
        drain_results();

        // alternate layout again, last stretch with no idling
        write_layout(1'b1);
        random_scans(350);
        calm = 1'b1;
        random_scans(150);
        drain_results();

        if (scoreboard.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/kse_pkg.sv
sv/keypad_scan_event_engine_unit.sv
sv/kse_checker.sv
bench/kse_bench_pkg.sv
bench/testbench.sv
